// ===== hdl/lls_pkg.sv =====
// ============================================================================
// Lua line context scanner package
// Shared types, context codes and character codes for the scanner.
// ============================================================================
`default_nettype none

package lls_pkg;

    // Default widths for the position counters and the long bracket level.
    localparam int POS_BITS_DEF   = 16;
    localparam int LEVEL_BITS_DEF = 8;

    // Context codes as seen on the configuration port and in results.
    localparam logic [1:0] CTX_MISC    = 2'd0;
    localparam logic [1:0] CTX_IDENT   = 2'd1;
    localparam logic [1:0] CTX_STRING  = 2'd2;
    localparam logic [1:0] CTX_COMMENT = 2'd3;

    // Configuration register indexes.
    localparam logic REG_START_CONTEXT = 1'b0;
    localparam logic REG_START_LEVEL   = 1'b1;

    // Character codes that the scanner reacts to.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Scanner mode, one-hot.
    typedef enum logic [8:0] {
        MODE_MISC        = 9'b0_0000_0001,
        MODE_IDENT       = 9'b0_0000_0010,
        MODE_STRING      = 9'b0_0000_0100,
        MODE_COMMENT     = 9'b0_0000_1000,
        MODE_PEND_LBRACK = 9'b0_0001_0000,
        MODE_PEND_DASH   = 9'b0_0010_0000,
        MODE_CMT_OPEN    = 9'b0_0100_0000,
        MODE_PEND_CMT_BR = 9'b0_1000_0000,
        MODE_FRESH       = 9'b1_0000_0000
    } t_mode;

    // One input transaction.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  end_context;
        logic [15:0] token_start;
    } t_out_item;

    // Configuration handed to the scan core.
    typedef struct packed {
        logic [1:0] start_context;
        logic [7:0] start_level;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/lua_line_context_scanner_top.sv =====
// ============================================================================
// Lua line context scanner, top level
// Configuration registers, input and result handshakes around the scan core.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ---------------------------
//  input     in         i_in_valid / o_in_ready    char_code, last_char
//  result    out        o_out_valid / i_out_ready  end_context, token_start
//  config    in         APB psel/penable/pwrite    start_context, start_level
//
//  One character is taken per cycle unless a result waits untaken; the scan
//  core decides the next state combinationally, and a line's result appears
//  in the result register in the cycle after its last character is taken.
//  While a result waits in the result register, a new character is taken in
//  any cycle in which that result is taken too.
//  Reset clears the configuration to zero and puts the scanner at a line start.
//
`default_nettype none

module lua_line_context_scanner_top #(
    parameter int POS_BITS   = lls_pkg::POS_BITS_DEF,
    parameter int LEVEL_BITS = lls_pkg::LEVEL_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lls_pkg::t_in_item  i_in_data,
    // Result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lls_pkg::t_out_item      o_out_data,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    lls_pkg::t_cfg      r_cfg;
    lls_pkg::t_out_item w_result;
    lls_pkg::t_out_item r_out_data;
    logic               r_out_valid;
    logic               w_step;
    logic               w_cfg_write;

    // Configuration registers.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_context <= lls_pkg::CTX_MISC;
            r_cfg.start_level   <= '0;
        end else if (w_cfg_write) begin
            if (paddr[2] == lls_pkg::REG_START_CONTEXT) begin
                r_cfg.start_context <= pwdata[1:0];
            end else begin
                r_cfg.start_level <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lls_pkg::REG_START_CONTEXT) begin
            prdata = {30'd0, r_cfg.start_context};
        end else begin
            prdata = {24'd0, r_cfg.start_level};
        end
    end

    // Input handshake: a character is taken whenever the result register can move.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    lls_scan_core #(
        .POS_BITS   (POS_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && i_in_data.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && i_in_data.last_char) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A last character always yields a result in the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.last_char) |=> o_out_valid)
        else $error("last character taken without a result");

    // A character that is not last never raises a fresh result.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !(i_in_valid && o_in_ready && i_in_data.last_char))
        |=> !o_out_valid)
        else $error("result appeared without a last character");

    // The input side stalls only behind a result that is not being taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    // Misc and comment contexts carry no token start.
    a_token_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.end_context == lls_pkg::CTX_MISC ||
                         o_out_data.end_context == lls_pkg::CTX_COMMENT))
        |-> (o_out_data.token_start == 16'd0))
        else $error("token start set outside identifier or string");

endmodule

`default_nettype wire

// ===== hdl/lls_scan_core.sv =====
// ============================================================================
// Lua line context scanner core
// Holds the lexical state and computes the next state and the line result
// for one character per cycle, advancing only when i_step is high.
// ============================================================================
`default_nettype none

module lls_scan_core #(
    parameter int POS_BITS   = lls_pkg::POS_BITS_DEF,
    parameter int LEVEL_BITS = lls_pkg::LEVEL_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire lls_pkg::t_in_item i_item,
    input  wire lls_pkg::t_cfg     i_cfg,
    output lls_pkg::t_out_item     o_result
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    // Saturating increment of a level or an '=' run.
    function automatic logic [LEVEL_BITS-1:0] sat_inc(input logic [LEVEL_BITS-1:0] v);
        sat_inc = (v == LEVEL_MAX) ? LEVEL_MAX : v + 1'b1;
    endfunction

    lls_pkg::t_mode        r_mode, n_mode, c_mode;
    logic [LEVEL_BITS-1:0] r_level, n_level, c_level;
    logic [LEVEL_BITS-1:0] r_eq, n_eq, c_eq;
    logic                  r_arm, n_arm, c_arm;
    logic [7:0]            r_quote, n_quote, c_quote;
    logic                  r_esc, n_esc, c_esc;
    logic [POS_BITS-1:0]   r_pos, n_pos, c_pos;
    logic [POS_BITS-1:0]   r_start, n_start, c_start;

    logic [7:0]            w_ch;
    logic                  w_do_misc;
    logic                  w_newline;
    logic                  w_close_hit;
    logic [LEVEL_BITS:0]   w_eq_plus;
    lls_pkg::t_mode        w_end_mode;
    logic [1:0]            w_ctx;
    logic [31:0]           w_start32;

    assign w_ch      = i_item.char_code;
    assign w_newline = (w_ch == lls_pkg::CH_LF) || (w_ch == lls_pkg::CH_CR);

    // State seen by this character: a fresh line loads the carried-over context.
    always_comb begin
        c_mode  = r_mode;
        c_level = r_level;
        c_eq    = r_eq;
        c_arm   = r_arm;
        c_quote = r_quote;
        c_esc   = r_esc;
        c_pos   = r_pos;
        c_start = r_start;
        if (r_mode == lls_pkg::MODE_FRESH) begin
            case (i_cfg.start_context)
                lls_pkg::CTX_IDENT:   c_mode = lls_pkg::MODE_IDENT;
                lls_pkg::CTX_STRING:  c_mode = lls_pkg::MODE_STRING;
                lls_pkg::CTX_COMMENT: c_mode = lls_pkg::MODE_COMMENT;
                default:              c_mode = lls_pkg::MODE_MISC;
            endcase
            if (32'(i_cfg.start_level) > 32'(LEVEL_MAX)) begin
                c_level = LEVEL_MAX;
            end else begin
                c_level = LEVEL_BITS'(i_cfg.start_level);
            end
            c_eq    = '0;
            c_arm   = 1'b0;
            c_quote = '0;
            c_esc   = 1'b0;
            c_pos   = '0;
            c_start = '0;
        end
    end

    // A ']' closes the long form when armed and the '=' run plus one equals the level.
    assign w_eq_plus   = {1'b0, c_eq} + 1'b1;
    assign w_close_hit = (w_ch == lls_pkg::CH_RBRACK) && c_arm &&
                         (w_eq_plus == {1'b0, c_level});

    // Next-state decision for one character.
    always_comb begin
        n_mode    = c_mode;
        n_level   = c_level;
        n_eq      = c_eq;
        n_arm     = c_arm;
        n_quote   = c_quote;
        n_esc     = c_esc;
        n_start   = c_start;
        n_pos     = c_pos + 1'b1;
        w_do_misc = 1'b0;

        case (c_mode)
            lls_pkg::MODE_IDENT: begin
                if (!(w_ch inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                   lls_pkg::CH_UNDER, lls_pkg::CH_DOT,
                                   lls_pkg::CH_COLON})) begin
                    w_do_misc = 1'b1;
                end
            end
            lls_pkg::MODE_STRING, lls_pkg::MODE_COMMENT: begin
                if (c_level == '0) begin
                    if (c_mode == lls_pkg::MODE_COMMENT) begin
                        if (w_newline) begin
                            n_mode = lls_pkg::MODE_MISC;
                        end
                    end else if (c_esc) begin
                        n_esc = 1'b0;
                    end else if (w_ch == c_quote) begin
                        n_mode = lls_pkg::MODE_MISC;
                    end else if (w_ch == lls_pkg::CH_BSLASH) begin
                        n_esc = 1'b1;
                    end
                end else if (w_close_hit) begin
                    n_mode = lls_pkg::MODE_MISC;
                end else if (w_ch == lls_pkg::CH_RBRACK) begin
                    n_arm = 1'b1;
                    n_eq  = '0;
                end else if (w_ch == lls_pkg::CH_EQUALS && c_arm) begin
                    n_eq = sat_inc(c_eq);
                end else begin
                    n_arm = 1'b0;
                end
            end
            lls_pkg::MODE_PEND_LBRACK: begin
                if (w_ch == lls_pkg::CH_EQUALS) begin
                    n_eq = sat_inc(c_eq);
                end else if (w_ch == lls_pkg::CH_LBRACK) begin
                    n_start = c_pos + 1'b1;
                    n_mode  = lls_pkg::MODE_STRING;
                    n_level = sat_inc(c_eq);
                    n_arm   = 1'b0;
                    n_eq    = '0;
                end else begin
                    w_do_misc = 1'b1;
                end
            end
            lls_pkg::MODE_PEND_DASH: begin
                if (w_ch == lls_pkg::CH_DASH) begin
                    n_mode = lls_pkg::MODE_CMT_OPEN;
                end else begin
                    w_do_misc = 1'b1;
                end
            end
            lls_pkg::MODE_CMT_OPEN, lls_pkg::MODE_PEND_CMT_BR: begin
                if (w_ch == lls_pkg::CH_LBRACK && c_mode == lls_pkg::MODE_CMT_OPEN) begin
                    n_eq   = '0;
                    n_mode = lls_pkg::MODE_PEND_CMT_BR;
                end else if (w_ch == lls_pkg::CH_EQUALS &&
                             c_mode == lls_pkg::MODE_PEND_CMT_BR) begin
                    n_eq = sat_inc(c_eq);
                end else if (w_ch == lls_pkg::CH_LBRACK) begin
                    n_mode  = lls_pkg::MODE_COMMENT;
                    n_level = sat_inc(c_eq);
                    n_arm   = 1'b0;
                    n_eq    = '0;
                end else begin
                    // The opener failed: the rest of the line is a short comment.
                    n_level = '0;
                    n_mode  = w_newline ? lls_pkg::MODE_MISC : lls_pkg::MODE_COMMENT;
                end
            end
            default: begin
                w_do_misc = 1'b1;
            end
        endcase

        // Character handled in the misc context.
        if (w_do_misc) begin
            n_mode = lls_pkg::MODE_MISC;
            if (w_ch inside {[8'h61:8'h7A], [8'h41:8'h5A], lls_pkg::CH_UNDER}) begin
                n_start = c_pos;
                n_mode  = lls_pkg::MODE_IDENT;
            end else if (w_ch == lls_pkg::CH_SQUOTE || w_ch == lls_pkg::CH_DQUOTE) begin
                n_start = c_pos + 1'b1;
                n_quote = w_ch;
                n_level = '0;
                n_esc   = 1'b0;
                n_mode  = lls_pkg::MODE_STRING;
            end else if (w_ch == lls_pkg::CH_LBRACK) begin
                n_eq   = '0;
                n_mode = lls_pkg::MODE_PEND_LBRACK;
            end else if (w_ch == lls_pkg::CH_DASH) begin
                n_mode = lls_pkg::MODE_PEND_DASH;
            end
        end
    end

    // Final context of the line as it stands after this character.
    assign w_end_mode = n_mode;
    always_comb begin
        case (w_end_mode)
            lls_pkg::MODE_IDENT:       w_ctx = lls_pkg::CTX_IDENT;
            lls_pkg::MODE_STRING:      w_ctx = lls_pkg::CTX_STRING;
            lls_pkg::MODE_COMMENT,
            lls_pkg::MODE_CMT_OPEN,
            lls_pkg::MODE_PEND_CMT_BR: w_ctx = lls_pkg::CTX_COMMENT;
            default:                   w_ctx = lls_pkg::CTX_MISC;
        endcase
    end

    assign w_start32            = 32'(n_start);
    assign o_result.end_context = w_ctx;
    assign o_result.token_start = (w_ctx == lls_pkg::CTX_IDENT || w_ctx == lls_pkg::CTX_STRING)
                                  ? w_start32[15:0] : 16'd0;

    // Control state: a line end returns the scanner to the fresh-line mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lls_pkg::MODE_FRESH;
            r_arm  <= 1'b0;
            r_esc  <= 1'b0;
        end else if (i_step) begin
            r_mode <= i_item.last_char ? lls_pkg::MODE_FRESH : n_mode;
            r_arm  <= n_arm;
            r_esc  <= n_esc;
        end
    end

    // Data state: reloaded at every line start, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_level <= n_level;
            r_eq    <= n_eq;
            r_quote <= n_quote;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

endmodule

`default_nettype wire

// ===== test/lua_line_context_scanner_top_tb.sv =====
// ============================================================================
// Lua line context scanner, testbench
// Feeds source lines one character per transaction, predicts the context at
// each line end with a scanner mirror of its own, and checks every result.
// Covers a directed table, deep long-bracket lines, and random Lua-like
// fragments with noise under varying back-pressure.
// ============================================================================

module lua_line_context_scanner_top_tb;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int RANDOM_ITEMS    = 340;
    localparam int SUB_PHASES      = 8;
    localparam int HOLD_OFF_CYCLES = 400;

    // One row of the directed table: an optional start setting, one character
    // and, for line ends that are obvious, the result typed in by hand.
    typedef struct packed {
        logic        wr_cfg;
        logic [1:0]  cfg_ctx;
        logic [7:0]  cfg_lvl;
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [1:0]  exp_ctx;
        logic [15:0] exp_start;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    lls_pkg::t_in_item   i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    lls_pkg::t_out_item  o_out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    lua_line_context_scanner_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bookkeeping shared by the processes below.
    int                  cycle_count = 0;
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  hold_left = 0;
    int                  random_items_sent = 0;
    lls_pkg::t_out_item  line_results_due [$];
    lls_pkg::t_out_item  result_due;
    logic [7:0]          line_buf [$];

    // Scanner mirror: configuration and per-line state.
    logic [1:0]          cfg_context = lls_pkg::CTX_MISC;
    logic [7:0]          cfg_level = 8'd0;
    lls_pkg::t_mode      scan_mode = lls_pkg::MODE_FRESH;
    logic [7:0]          bracket_lvl = 8'd0;
    logic [7:0]          eq_run = 8'd0;
    logic                close_armed = 1'b0;
    logic [7:0]          quote_code = 8'd0;
    logic                escape_pending = 1'b0;
    logic [15:0]         char_pos = 16'd0;
    logic [15:0]         token_pos = 16'd0;

    // Directed table: extremes of the character code, every context and
    // the pending forms left hanging at a line end.
    t_row directed_rows [0:24] = '{
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, 8'hFF,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, 8'h00,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_LBRACK,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b1, 1'b1, lls_pkg::CTX_COMMENT, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, "x",
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DOT,
          1'b1, 1'b1, lls_pkg::CTX_IDENT, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, " ",
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DQUOTE,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_BSLASH,
          1'b1, 1'b1, lls_pkg::CTX_STRING, 16'd2},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_LBRACK,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_LBRACK,
          1'b1, 1'b1, lls_pkg::CTX_STRING, 16'd2},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_LBRACK,
          1'b1, 1'b1, lls_pkg::CTX_COMMENT, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, "z",
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_CR,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_DASH,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, lls_pkg::CH_LF,
          1'b1, 1'b1, lls_pkg::CTX_MISC, 16'd0},
        '{1'b1, lls_pkg::CTX_STRING, 8'd0, "a",
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b1 ^ 1'b1, lls_pkg::CTX_MISC, 8'd0, 8'h00,
          1'b0, 1'b0, lls_pkg::CTX_MISC, 16'd0},
        '{1'b0, lls_pkg::CTX_MISC, 8'd0, "b",
          1'b1, 1'b1, lls_pkg::CTX_IDENT, 16'd2},
        '{1'b1, lls_pkg::CTX_COMMENT, 8'd255, lls_pkg::CH_RBRACK,
          1'b1, 1'b1, lls_pkg::CTX_COMMENT, 16'd0}
    };

    // ------------------------------------------------------------------
    // Scanner mirror
    // ------------------------------------------------------------------

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9") || c == lls_pkg::CH_UNDER ||
               c == lls_pkg::CH_DOT || c == lls_pkg::CH_COLON;
    endfunction

    // Levels and runs of '=' stick at the top of their range.
    function automatic logic [7:0] level_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void open_long_form(input lls_pkg::t_mode next_mode);
        scan_mode = next_mode;
        bracket_lvl = level_inc(eq_run);
        close_armed = 1'b0;
        eq_run = 8'd0;
    endfunction

    // True when the character completes ']' '='... ']' at the open level.
    function automatic bit long_form_closes(input logic [7:0] c);
        if (c == lls_pkg::CH_RBRACK) begin
            if (close_armed && int'(eq_run) + 1 == int'(bracket_lvl)) begin
                return 1'b1;
            end
            close_armed = 1'b1;
            eq_run = 8'd0;
        end else if (c == lls_pkg::CH_EQUALS && close_armed) begin
            eq_run = level_inc(eq_run);
        end else begin
            close_armed = 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic void misc_step(input logic [7:0] c, input logic [15:0] pos);
        if (is_letter(c) || c == lls_pkg::CH_UNDER) begin
            token_pos = pos;
            scan_mode = lls_pkg::MODE_IDENT;
        end else if (c == lls_pkg::CH_SQUOTE || c == lls_pkg::CH_DQUOTE) begin
            token_pos = pos + 16'd1;
            quote_code = c;
            bracket_lvl = 8'd0;
            escape_pending = 1'b0;
            scan_mode = lls_pkg::MODE_STRING;
        end else if (c == lls_pkg::CH_LBRACK) begin
            eq_run = 8'd0;
            scan_mode = lls_pkg::MODE_PEND_LBRACK;
        end else if (c == lls_pkg::CH_DASH) begin
            scan_mode = lls_pkg::MODE_PEND_DASH;
        end
    endfunction

    function automatic void short_comment_step(input logic [7:0] c);
        bracket_lvl = 8'd0;
        scan_mode = (c == lls_pkg::CH_LF || c == lls_pkg::CH_CR) ?
                    lls_pkg::MODE_MISC : lls_pkg::MODE_COMMENT;
    endfunction

    function automatic void scan_step(input logic [7:0] c, input logic [15:0] pos);
        case (scan_mode)
            lls_pkg::MODE_IDENT: begin
                if (!is_word_char(c)) begin
                    scan_mode = lls_pkg::MODE_MISC;
                    misc_step(c, pos);
                end
            end
            lls_pkg::MODE_STRING, lls_pkg::MODE_COMMENT: begin
                if (bracket_lvl != 8'd0) begin
                    if (long_form_closes(c)) scan_mode = lls_pkg::MODE_MISC;
                end else if (scan_mode == lls_pkg::MODE_COMMENT) begin
                    if (c == lls_pkg::CH_LF || c == lls_pkg::CH_CR) begin
                        scan_mode = lls_pkg::MODE_MISC;
                    end
                end else if (escape_pending) begin
                    escape_pending = 1'b0;
                end else if (c == quote_code) begin
                    scan_mode = lls_pkg::MODE_MISC;
                end else if (c == lls_pkg::CH_BSLASH) begin
                    escape_pending = 1'b1;
                end
            end
            lls_pkg::MODE_PEND_LBRACK: begin
                if (c == lls_pkg::CH_EQUALS) begin
                    eq_run = level_inc(eq_run);
                end else if (c == lls_pkg::CH_LBRACK) begin
                    token_pos = pos + 16'd1;
                    open_long_form(lls_pkg::MODE_STRING);
                end else begin
                    scan_mode = lls_pkg::MODE_MISC;
                    misc_step(c, pos);
                end
            end
            lls_pkg::MODE_PEND_DASH: begin
                if (c == lls_pkg::CH_DASH) begin
                    scan_mode = lls_pkg::MODE_CMT_OPEN;
                end else begin
                    scan_mode = lls_pkg::MODE_MISC;
                    misc_step(c, pos);
                end
            end
            lls_pkg::MODE_CMT_OPEN: begin
                if (c == lls_pkg::CH_LBRACK) begin
                    eq_run = 8'd0;
                    scan_mode = lls_pkg::MODE_PEND_CMT_BR;
                end else begin
                    short_comment_step(c);
                end
            end
            lls_pkg::MODE_PEND_CMT_BR: begin
                if (c == lls_pkg::CH_EQUALS) eq_run = level_inc(eq_run);
                else if (c == lls_pkg::CH_LBRACK) open_long_form(lls_pkg::MODE_COMMENT);
                else short_comment_step(c);
            end
            default: begin
                scan_mode = lls_pkg::MODE_MISC;
                misc_step(c, pos);
            end
        endcase
    endfunction

    // Advances the mirror by one character; returns 1 with the line's
    // context and token start when the character ends a line.
    function automatic bit predict_line_context(input lls_pkg::t_in_item item,
                                                output lls_pkg::t_out_item res);
        logic [1:0] ctx;
        res = '0;
        if (scan_mode == lls_pkg::MODE_FRESH) begin
            case (cfg_context)
                lls_pkg::CTX_MISC:   scan_mode = lls_pkg::MODE_MISC;
                lls_pkg::CTX_IDENT:  scan_mode = lls_pkg::MODE_IDENT;
                lls_pkg::CTX_STRING: scan_mode = lls_pkg::MODE_STRING;
                default:             scan_mode = lls_pkg::MODE_COMMENT;
            endcase
            bracket_lvl = cfg_level;
            eq_run = 8'd0;
            close_armed = 1'b0;
            quote_code = 8'd0;
            escape_pending = 1'b0;
            char_pos = 16'd0;
            token_pos = 16'd0;
        end
        scan_step(item.char_code, char_pos);
        char_pos = char_pos + 16'd1;
        if (!item.last_char) return 1'b0;
        case (scan_mode)
            lls_pkg::MODE_IDENT:       ctx = lls_pkg::CTX_IDENT;
            lls_pkg::MODE_STRING:      ctx = lls_pkg::CTX_STRING;
            lls_pkg::MODE_COMMENT,
            lls_pkg::MODE_CMT_OPEN,
            lls_pkg::MODE_PEND_CMT_BR: ctx = lls_pkg::CTX_COMMENT;
            default:                   ctx = lls_pkg::CTX_MISC;
        endcase
        res.end_context = ctx;
        res.token_start = (ctx == lls_pkg::CTX_IDENT || ctx == lls_pkg::CTX_STRING) ?
                          token_pos : 16'd0;
        scan_mode = lls_pkg::MODE_FRESH;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Each result transaction is matched against the oldest line end due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_results_due.size() == 0) begin
                flag_mismatch("result with no line end due", 32'(o_out_data), 32'd0);
            end else begin
                result_due = line_results_due.pop_front();
                if (o_out_data.end_context != result_due.end_context) begin
                    flag_mismatch("end_context", 32'(o_out_data.end_context),
                                  32'(result_due.end_context));
                end
                if (o_out_data.token_start != result_due.token_start) begin
                    flag_mismatch("token_start", 32'(o_out_data.token_start),
                                  32'(result_due.token_start));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == lls_pkg::REG_START_CONTEXT) cfg_context = value[1:0];
        else cfg_level = value[7:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [7:0] want);
        logic [31:0] got;
        logic [31:0] mask;
        mask = (idx == lls_pkg::REG_START_CONTEXT) ? 32'h3 : 32'hFF;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata & mask;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got != {24'd0, want}) flag_mismatch("register read", got, {24'd0, want});
    endtask

    task automatic set_line_start(input logic [1:0] ctx, input logic [7:0] lvl);
        apb_write(lls_pkg::REG_START_CONTEXT, {30'd0, ctx});
        apb_write(lls_pkg::REG_START_LEVEL, {24'd0, lvl});
        check_register(lls_pkg::REG_START_CONTEXT, {6'd0, ctx});
        check_register(lls_pkg::REG_START_LEVEL, lvl);
    endtask

    // ------------------------------------------------------------------
    // Character transactions
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                             input lls_pkg::t_out_item typed_res);
        lls_pkg::t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.char_code = c;
        i_in_data.last_char = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_line_context(i_in_data, predicted)) begin
            line_results_due.push_back(typed ? typed_res : predicted);
        end
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
        end
    endtask

    // Stops sending and waits until every result due has been taken, then
    // pauses before the start setting changes.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (line_results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_from(input string pool);
        return pool.getc($urandom_range(pool.len() - 1));
    endfunction

    function automatic void push_run(input logic [7:0] c, input int n);
        repeat (n) line_buf.push_back(c);
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(97, 122));
            1:       return 8'($urandom_range(65, 90));
            2:       return 8'($urandom_range(48, 57));
            default: return pick_from("_.:");
        endcase
    endfunction

    // String and comment body: mostly printable, with quotes, escapes,
    // brackets, line breaks and the odd high code mixed in.
    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(9))
            0, 1:    return pick_from("\\\"']=[- ");
            2:       return pick_from("\n\r");
            3:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic void push_long_form(input bit is_comment);
        int k;
        k = $urandom_range(3);
        if (is_comment) push_run(lls_pkg::CH_DASH, 2);
        line_buf.push_back(lls_pkg::CH_LBRACK);
        push_run(lls_pkg::CH_EQUALS, k);
        line_buf.push_back(lls_pkg::CH_LBRACK);
        repeat ($urandom_range(6)) line_buf.push_back(pick_from("a ]=[-"));
        if ($urandom_range(3) != 0) begin
            line_buf.push_back(lls_pkg::CH_RBRACK);
            push_run(lls_pkg::CH_EQUALS, ($urandom_range(4) == 0) ? $urandom_range(3) : k);
            line_buf.push_back(lls_pkg::CH_RBRACK);
        end
    endfunction

    // A line of Lua-like fragments with random content; some lines are cut
    // short at a random point, so that they can end inside a pending bracket or dash.
    function automatic void build_random_line();
        logic [7:0] q;
        int cut;
        line_buf.delete();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(9))
                0, 1: begin
                    line_buf.push_back(($urandom_range(4) == 0) ? lls_pkg::CH_UNDER :
                                       8'($urandom_range(97, 122)));
                    repeat ($urandom_range(5)) line_buf.push_back(pick_word_char());
                end
                2: begin
                    q = ($urandom_range(1) != 0) ? lls_pkg::CH_DQUOTE : lls_pkg::CH_SQUOTE;
                    line_buf.push_back(q);
                    repeat ($urandom_range(6)) line_buf.push_back(pick_text_char());
                    if ($urandom_range(4) != 0) line_buf.push_back(q);
                end
                3: push_long_form(1'b0);
                4: begin
                    push_run(lls_pkg::CH_DASH, 2);
                    repeat ($urandom_range(5)) line_buf.push_back(pick_text_char());
                    if ($urandom_range(1) != 0) line_buf.push_back(pick_from("\n\r"));
                end
                5: push_long_form(1'b1);
                6: repeat ($urandom_range(1, 3)) line_buf.push_back(pick_from(" (,=-[])"));
                7: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(255)));
                8: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(48, 57)));
                default: push_run(" ", $urandom_range(1, 3));
            endcase
        end
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, line_buf.size());
            while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        lls_pkg::t_out_item typed_res;
        int target;
        logic [1:0] phase_ctx [0:5];
        logic [7:0] phase_lvl [0:5];

        phase_ctx = '{lls_pkg::CTX_MISC, lls_pkg::CTX_IDENT, lls_pkg::CTX_STRING,
                      lls_pkg::CTX_COMMENT, lls_pkg::CTX_STRING, lls_pkg::CTX_COMMENT};
        phase_lvl = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd255};

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        check_register(lls_pkg::REG_START_CONTEXT, 8'd0);
        check_register(lls_pkg::REG_START_LEVEL, 8'd0);

        // Directed table, under the first idling pattern.
        send_idle_pct = 26;
        recv_idle_pct = 70;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].wr_cfg) begin
                wait_drained();
                set_line_start(directed_rows[i].cfg_ctx, directed_rows[i].cfg_lvl);
            end
            typed_res.end_context = directed_rows[i].exp_ctx;
            typed_res.token_start = directed_rows[i].exp_start;
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, typed_res);
        end

        // Random lines: three idling patterns, a new start setting per phase
        // and one long result-side hold-off to fill the block up.
        for (int p = 0; p < SUB_PHASES; p++) begin
            wait_drained();
            if (p < 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 70;
            end else if (p < 6) begin
                send_idle_pct = 70;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p < 6) set_line_start(phase_ctx[p], phase_lvl[p]);
            else set_line_start(2'($urandom_range(3)), 8'($urandom_range(255)));
            if (p == 3) hold_requests++;
            target = (RANDOM_ITEMS * (p + 1)) / SUB_PHASES;
            while (random_items_sent < target) begin
                build_random_line();
                send_line();
                random_items_sent += line_buf.size();
            end
        end

        // Saturated long-bracket levels.
        wait_drained();
        set_line_start(lls_pkg::CTX_MISC, 8'd0);

        // Over-long '=' run opens a long string at the top level.
        line_buf.delete();
        line_buf.push_back(lls_pkg::CH_LBRACK);
        push_run(lls_pkg::CH_EQUALS, 300);
        line_buf.push_back(lls_pkg::CH_LBRACK);
        line_buf.push_back("a");
        line_buf.push_back(lls_pkg::CH_RBRACK);
        push_run(lls_pkg::CH_EQUALS, 254);
        line_buf.push_back(lls_pkg::CH_RBRACK);
        line_buf.push_back("q");
        send_line();

        // Same for a long comment.
        line_buf.delete();
        push_run(lls_pkg::CH_DASH, 2);
        line_buf.push_back(lls_pkg::CH_LBRACK);
        push_run(lls_pkg::CH_EQUALS, 256);
        line_buf.push_back(lls_pkg::CH_LBRACK);
        line_buf.push_back("c");
        line_buf.push_back(lls_pkg::CH_RBRACK);
        push_run(lls_pkg::CH_EQUALS, 254);
        line_buf.push_back(lls_pkg::CH_RBRACK);
        line_buf.push_back("z");
        send_line();

        // A long string carried in at the top level and closed on this line.
        wait_drained();
        set_line_start(lls_pkg::CTX_STRING, 8'd255);
        line_buf.delete();
        line_buf.push_back("x");
        line_buf.push_back(lls_pkg::CH_RBRACK);
        push_run(lls_pkg::CH_EQUALS, 254);
        line_buf.push_back(lls_pkg::CH_RBRACK);
        line_buf.push_back("y");
        send_line();

        // Let every outstanding result arrive, then a short settling pause.
        i_in_valid = 1'b0;
        while (line_results_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
